// ----- rtl/core/mp2d_pkg.sv -----
package mp2d_pkg;

   // Store dimensions
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_CHANNELS = 16;
   localparam int MAX_WINDOW   = 8;

   localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ROW_IDX_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int COL_IDX_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Fixed field widths
   localparam int POS_W   = 6;
   localparam int CHAN_W  = 4;
   localparam int DATA_W  = 8;
   localparam int MAP_W   = 7;
   localparam int WIN_W   = 4;
   localparam int PAD_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // Signed width for window geometry (row * stride - pad, plus window)
   localparam int GEO_W = 12;

   // Commands
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAP_ROWS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_COLS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_ROWS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COLUMNS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_ABOVE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_BEFORE    = 3'd7;

   typedef struct packed {
      logic [MAP_W-1:0] map_rows;
      logic [MAP_W-1:0] map_cols;
      logic [WIN_W-1:0] window_height;
      logic [WIN_W-1:0] window_width;
      logic [WIN_W-1:0] step_rows;
      logic [WIN_W-1:0] step_columns;
      logic [PAD_W-1:0] pad_above;
      logic [PAD_W-1:0] pad_before;
   } cfg_type;

   // Clamped window bounds, inclusive
   typedef struct packed {
      logic                 empty;
      logic [ROW_IDX_W-1:0] row_first;
      logic [ROW_IDX_W-1:0] row_last;
      logic [COL_IDX_W-1:0] col_first;
      logic [COL_IDX_W-1:0] col_last;
      logic [CHAN_W-1:0]    chan;
   } geom_type;

   function automatic logic [ADDR_W-1:0] store_addr(
      input logic [ROW_IDX_W-1:0] r,
      input logic [COL_IDX_W-1:0] c,
      input logic [CHAN_W-1:0]    ch
   );
      int lin;
      lin = (int'(r) * MAX_WIDTH + int'(c)) * MAX_CHANNELS + int'(ch);
      return ADDR_W'(lin);
   endfunction

endpackage

// ----- rtl/core/mp2d_ram.sv -----
module mp2d_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
   logic [DATA_W-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/mp2d_geom.sv -----
module mp2d_geom (
   input  logic                       clock,
   input  logic                       load,
   input  mp2d_pkg::cfg_type          cfg,
   input  logic [mp2d_pkg::POS_W-1:0]  row,
   input  logic [mp2d_pkg::POS_W-1:0]  col,
   input  logic [mp2d_pkg::CHAN_W-1:0] chan,
   output mp2d_pkg::geom_type         geom
);

   localparam int GW = mp2d_pkg::GEO_W;

   logic signed [GW-1:0] oy, ox;
   logic signed [GW-1:0] h_lim, w_lim, wh_lim, ww_lim;
   logic signed [GW-1:0] r0, r1, c0, c1;
   logic                 chan_bad;
   mp2d_pkg::geom_type   geom_in;
   mp2d_pkg::geom_type   geom_ff;

   // Saturate map and window sizes
   always_comb begin
      h_lim  = (int'(cfg.map_rows) > mp2d_pkg::MAX_HEIGHT) ?
               GW'(mp2d_pkg::MAX_HEIGHT) : GW'(cfg.map_rows);
      w_lim  = (int'(cfg.map_cols) > mp2d_pkg::MAX_WIDTH) ?
               GW'(mp2d_pkg::MAX_WIDTH) : GW'(cfg.map_cols);
      wh_lim = (int'(cfg.window_height) > mp2d_pkg::MAX_WINDOW) ?
               GW'(mp2d_pkg::MAX_WINDOW) : GW'(cfg.window_height);
      ww_lim = (int'(cfg.window_width) > mp2d_pkg::MAX_WINDOW) ?
               GW'(mp2d_pkg::MAX_WINDOW) : GW'(cfg.window_width);
   end

   // Window origin and clamped bounds (end is exclusive)
   always_comb begin
      oy = GW'(row) * GW'(cfg.step_rows) - GW'(cfg.pad_above);
      ox = GW'(col) * GW'(cfg.step_columns) - GW'(cfg.pad_before);
      r0 = (oy < 0) ? '0 : oy;
      c0 = (ox < 0) ? '0 : ox;
      r1 = ((oy + wh_lim) < h_lim) ? (oy + wh_lim) : h_lim;
      c1 = ((ox + ww_lim) < w_lim) ? (ox + ww_lim) : w_lim;
      chan_bad = !(int'(chan) < mp2d_pkg::MAX_CHANNELS);

      geom_in.empty     = (r0 >= r1) || (c0 >= c1) || chan_bad;
      geom_in.row_first = mp2d_pkg::ROW_IDX_W'(r0);
      geom_in.row_last  = mp2d_pkg::ROW_IDX_W'(r1 - GW'(1));
      geom_in.col_first = mp2d_pkg::COL_IDX_W'(c0);
      geom_in.col_last  = mp2d_pkg::COL_IDX_W'(c1 - GW'(1));
      geom_in.chan      = chan;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         geom_ff <= geom_in;
      end
   end

   assign geom = geom_ff;

endmodule

// ----- rtl/core/max_pool_2d_u8.sv -----
// Channel   Ports                                          Direction
// req       req_valid/req_stall, cmd row col chan value    in
// rsp       rsp_valid/rsp_stall, max_value empty_window    out
// csr       csr_we, csr_index, csr_wdata                   in (write only)
//
// A load with an in-range position is written to the store at its transfer edge.
// A query computes the geometry, then reads the clamped window one element
// a cycle from the single-port store, then takes the last read data; an empty
// window (wholly padded, or a channel out of range) skips the reads.
// Reset is synchronous; it clears control and configuration, not the store.
// A stalled result sits in the output register while the next item is taken.
module max_pool_2d_u8 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [mp2d_pkg::POS_W-1:0]         req_row,
   input  logic [mp2d_pkg::POS_W-1:0]         req_col,
   input  logic [mp2d_pkg::CHAN_W-1:0]        req_chan,
   input  logic [mp2d_pkg::DATA_W-1:0]        req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mp2d_pkg::DATA_W-1:0]        rsp_max_value,
   output logic                              rsp_empty_window,
   input  logic                              csr_we,
   input  logic [mp2d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mp2d_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GEOM  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   mp2d_pkg::cfg_type                   cfg_ff, cfg_in;
   mp2d_pkg::geom_type                  geom;
   logic [mp2d_pkg::ROW_IDX_W-1:0]      cur_row_ff, cur_row_in;
   logic [mp2d_pkg::COL_IDX_W-1:0]      cur_col_ff, cur_col_in;
   logic                                rd_pend_ff;
   logic [mp2d_pkg::DATA_W-1:0]         max_ff, max_in;
   logic [mp2d_pkg::DATA_W-1:0]         rd_data;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mp2d_pkg::DATA_W-1:0]         rsp_max_ff, rsp_max_in;
   logic                                rsp_empty_ff, rsp_empty_in;
   logic                                req_xfer, load_xfer, query_xfer;
   logic                                load_ok, out_free, last_elem;
   logic                                ram_en, ram_we;
   logic [mp2d_pkg::ADDR_W-1:0]         ram_addr;

   // Input handshake
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign load_xfer  = req_xfer && (req_cmd == mp2d_pkg::CMD_LOAD);
   assign query_xfer = req_xfer && (req_cmd == mp2d_pkg::CMD_QUERY);
   assign load_ok    = (int'(req_row) < mp2d_pkg::MAX_HEIGHT) &&
                       (int'(req_col) < mp2d_pkg::MAX_WIDTH) &&
                       (int'(req_chan) < mp2d_pkg::MAX_CHANNELS);

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mp2d_pkg::REG_MAP_ROWS:      cfg_in.map_rows      = csr_wdata;
            mp2d_pkg::REG_MAP_COLS:      cfg_in.map_cols      = csr_wdata;
            mp2d_pkg::REG_WINDOW_HEIGHT: cfg_in.window_height = csr_wdata[3:0];
            mp2d_pkg::REG_WINDOW_WIDTH:  cfg_in.window_width  = csr_wdata[3:0];
            mp2d_pkg::REG_STEP_ROWS:     cfg_in.step_rows     = csr_wdata[3:0];
            mp2d_pkg::REG_STEP_COLUMNS:  cfg_in.step_columns  = csr_wdata[3:0];
            mp2d_pkg::REG_PAD_ABOVE:     cfg_in.pad_above     = csr_wdata[2:0];
            mp2d_pkg::REG_PAD_BEFORE:    cfg_in.pad_before    = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_rows      <= 7'd64;
         cfg_ff.map_cols      <= 7'd64;
         cfg_ff.window_height <= 4'd2;
         cfg_ff.window_width  <= 4'd2;
         cfg_ff.step_rows     <= 4'd2;
         cfg_ff.step_columns  <= 4'd2;
         cfg_ff.pad_above     <= 3'd0;
         cfg_ff.pad_before    <= 3'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Window geometry, registered at the query transfer
   mp2d_geom u_geom (
      .clock (clock),
      .load  (query_xfer),
      .cfg   (cfg_ff),
      .row   (req_row),
      .col   (req_col),
      .chan  (req_chan),
      .geom  (geom)
   );

   // Feature store: loads write in idle, the scan reads
   assign ram_we   = load_xfer && load_ok;
   assign ram_en   = ram_we || (state_ff == ST_SCAN);
   assign ram_addr = ram_we ?
                     mp2d_pkg::store_addr(mp2d_pkg::ROW_IDX_W'(req_row),
                                          mp2d_pkg::COL_IDX_W'(req_col), req_chan) :
                     mp2d_pkg::store_addr(cur_row_ff, cur_col_ff, geom.chan);

   mp2d_ram #(
      .ADDR_W (mp2d_pkg::ADDR_W),
      .DATA_W (mp2d_pkg::DATA_W)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_value),
      .rdata (rd_data)
   );

   // Running maximum over returned read data
   assign max_in = (rd_pend_ff && (rd_data > max_ff)) ? rd_data : max_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_elem = (cur_row_ff == geom.row_last) && (cur_col_ff == geom.col_last);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_max_in   = rsp_max_ff;
      rsp_empty_in = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_xfer) begin
               state_in = ST_GEOM;
            end
         end
         ST_GEOM: begin
            cur_row_in = geom.row_first;
            cur_col_in = geom.col_first;
            if (!geom.empty) begin
               state_in = ST_SCAN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = '0;
               rsp_empty_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (cur_col_ff == geom.col_last) begin
               cur_col_in = geom.col_first;
               cur_row_in = cur_row_ff + mp2d_pkg::ROW_IDX_W'(1);
            end else begin
               cur_col_in = cur_col_ff + mp2d_pkg::COL_IDX_W'(1);
            end
            if (last_elem) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = max_in;
               rsp_empty_in = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = geom.empty ? '0 : max_ff;
               rsp_empty_in = geom.empty;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_empty_ff <= rsp_empty_in;
      if (state_ff == ST_GEOM) begin
         max_ff <= '0;
      end else begin
         max_ff <= max_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_empty_window = rsp_empty_ff;

   // Checks
   a_pend_after_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff) == ST_SCAN)
      else $error("read data pending without a scan read");

   a_query_to_geom: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> state_ff == ST_GEOM)
      else $error("query transfer did not start geometry");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cur_row_ff >= geom.row_first) &&
      (cur_row_ff <= geom.row_last) && (cur_col_ff >= geom.col_first) &&
      (cur_col_ff <= geom.col_last))
      else $error("scan pointer outside window");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_IDLE && !rd_pend_ff)
      else $error("store write during a scan");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_GEOM) ||
      ($past(state_ff) == ST_DRAIN) || ($past(state_ff) == ST_DONE))
      else $error("result raised outside a query");

endmodule
